// File: rtl/pip_pkg.sv
// ---------------------------------------------------------------------------
// pip_pkg: shared constants and types of the point-in-polygon tester
// Port widths, command and mode codes, register indexes, step control.
// ---------------------------------------------------------------------------
package pip_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_COORD_BITS   = 16;

	localparam int IN_COORD_W = 16;
	localparam int INDEX_W    = 6;
	localparam int WN_W       = 8;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 7;
	localparam int COUNT_W    = 7;
	localparam int MODE_W     = 2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_TEST_MODE    = 1'b1;

	localparam logic [MODE_W-1:0] MODE_HALFPLANE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CROSSING  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WINDING   = 2'd2;

	localparam logic [COUNT_W-1:0] RESET_VERTEX_COUNT = 7'd3;
	localparam logic [MODE_W-1:0]  RESET_TEST_MODE    = MODE_CROSSING;

	// control that travels with one edge step through the edge unit
	typedef struct packed {
		logic valid;
		logic last;
	} step_ctl_t;

endpackage

// File: rtl/pip_vertex_cell.sv
// ---------------------------------------------------------------------------
// pip_vertex_cell: one vertex slot of the rotating ring
// Holds one vertex; loads it directly or takes the neighbor's vertex.
// ---------------------------------------------------------------------------
module pip_vertex_cell #(
	parameter int COORD_BITS = pip_pkg::DEF_COORD_BITS
) (
	input  logic                    clk,
	input  logic                    load_en,
	input  logic [2*COORD_BITS-1:0] load_xy,
	input  logic                    rot_en,
	input  logic [2*COORD_BITS-1:0] next_xy,
	output logic [2*COORD_BITS-1:0] xy
);

	logic [2*COORD_BITS-1:0] xy_q;

	// load a vertex, or advance the ring by one slot
	always_ff @(posedge clk) begin
		if (load_en) begin
			xy_q <= load_xy;
		end else if (rot_en) begin
			xy_q <= next_xy;
		end
	end

	assign xy = xy_q;

endmodule

// File: rtl/pip_edge_unit.sv
// ---------------------------------------------------------------------------
// pip_edge_unit: per-edge tests and accumulation
// Differences, products, then compare and accumulate, one edge per cycle.
// ---------------------------------------------------------------------------
module pip_edge_unit #(
	parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  logic [pip_pkg::MODE_W-1:0]     mode,
	input  pip_pkg::step_ctl_t             step,
	input  logic [2*COORD_BITS-1:0]        v0,
	input  logic [2*COORD_BITS-1:0]        v1,
	input  logic [2*COORD_BITS-1:0]        v2,
	input  logic [2*COORD_BITS-1:0]        pt,
	output logic                           done,
	output logic                           inside_res,
	output logic signed [pip_pkg::WN_W-1:0] winding_number,
	output logic                           is_convex
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int AW = $clog2(MAX_VERTICES) + 2;
	localparam int WN_W_L = pip_pkg::WN_W;

	logic signed [CW-1:0] x0, y0, x1, y1, x2, y2, px, py;

	assign {x0, y0} = v0;
	assign {x1, y1} = v1;
	assign {x2, y2} = v2;
	assign {px, py} = pt;

	pip_pkg::step_ctl_t ctl_s1, ctl_s2;
	logic signed [DW-1:0] dx01_s1, dy01_s1, dx02_s1, dy02_s1, dxp0_s1, dyp0_s1;
	logic signed [DW-1:0] dx10_s1, dyp1_s1, dxp1_s1, dy10_s1;
	logic cross_e_s1, up_s1, down_s1, den_pos_s1, den_neg_s1;
	logic signed [PW-1:0] cv1_s2, cv2_s2, hp1_s2, hp2_s2, num_s2, lhs_s2;
	logic cross_e_s2, up_s2, down_s2, den_pos_s2, den_neg_s2;

	// stage 1: coordinate differences and y-order flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		dx01_s1    <= DW'(x1) - DW'(x0);
		dy01_s1    <= DW'(y1) - DW'(y0);
		dx02_s1    <= DW'(x2) - DW'(x0);
		dy02_s1    <= DW'(y2) - DW'(y0);
		dxp0_s1    <= DW'(px) - DW'(x0);
		dyp0_s1    <= DW'(py) - DW'(y0);
		dx10_s1    <= DW'(x0) - DW'(x1);
		dyp1_s1    <= DW'(py) - DW'(y1);
		dxp1_s1    <= DW'(px) - DW'(x1);
		dy10_s1    <= DW'(y0) - DW'(y1);
		cross_e_s1 <= (y0 < py) ^ (y1 < py);
		up_s1      <= (y0 <= py) && (y1 > py);
		down_s1    <= (y0 > py) && (y1 <= py);
		den_pos_s1 <= y0 > y1;
		den_neg_s1 <= y0 < y1;
	end

	// stage 2: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		cv1_s2     <= PW'(dx01_s1) * PW'(dy02_s1);
		cv2_s2     <= PW'(dx02_s1) * PW'(dy01_s1);
		hp1_s2     <= PW'(dx01_s1) * PW'(dyp0_s1);
		hp2_s2     <= PW'(dxp0_s1) * PW'(dy01_s1);
		num_s2     <= PW'(dx10_s1) * PW'(dyp1_s1);
		lhs_s2     <= PW'(dxp1_s1) * PW'(dy10_s1);
		cross_e_s2 <= cross_e_s1;
		up_s2      <= up_s1;
		down_s2    <= down_s1;
		den_pos_s2 <= den_pos_s1;
		den_neg_s2 <= den_neg_s1;
	end

	// stage 3: edge decisions
	logic signed [XW-1:0] cvx, hpc;
	logic crossed, wn_inc, wn_dec;

	assign cvx     = XW'(cv1_s2) - XW'(cv2_s2);
	assign hpc     = XW'(hp1_s2) - XW'(hp2_s2);
	assign crossed = cross_e_s2 &&
		((den_pos_s2 && (lhs_s2 < num_s2)) || (den_neg_s2 && (lhs_s2 > num_s2)));
	assign wn_inc  = up_s2 && (hpc > 0);
	assign wn_dec  = down_s2 && (hpc < 0);

	logic                 halfplane_q, convex_q, parity_q;
	logic signed [AW-1:0] wn_q;
	logic                 halfplane_d, convex_d, parity_d;
	logic signed [AW-1:0] wn_d;
	logic signed [WN_W_L-1:0] wn_sat;

	always_comb begin
		halfplane_d = halfplane_q && !(hpc < 0);
		convex_d    = convex_q && !(cvx < 0);
		parity_d    = parity_q ^ crossed;
		wn_d        = wn_q + AW'(wn_inc) - AW'(wn_dec);
		if (wn_d > 127) begin
			wn_sat = WN_W_L'(127);
		end else if (wn_d < -128) begin
			wn_sat = WN_W_L'(-128);
		end else begin
			wn_sat = WN_W_L'(wn_d);
		end
	end

	// accumulate over the edges; clear at each new query request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halfplane_q <= 1'b1;
			convex_q    <= 1'b1;
			parity_q    <= 1'b0;
			wn_q        <= '0;
		end else if (clear) begin
			halfplane_q <= 1'b1;
			convex_q    <= 1'b1;
			parity_q    <= 1'b0;
			wn_q        <= '0;
		end else if (ctl_s2.valid) begin
			halfplane_q <= halfplane_d;
			convex_q    <= convex_d;
			parity_q    <= parity_d;
			wn_q        <= wn_d;
		end
	end

	// register the result on the last edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && ctl_s2.last) begin
			winding_number <= wn_sat;
			is_convex      <= convex_d;
			case (mode)
				pip_pkg::MODE_HALFPLANE: inside_res <= halfplane_d;
				pip_pkg::MODE_CROSSING:  inside_res <= parity_d;
				default:                 inside_res <= (wn_d != 0);
			endcase
		end
	end

endmodule

// File: rtl/point_in_polygon_tester.sv
// ---------------------------------------------------------------------------
// point_in_polygon_tester: polygon store and point query engine
// Vertices sit in a ring of cells that rotates once per query.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge with start high and busy low.
//   command = load writes (coord_x, coord_y) into slot vertex_index in that
//   cycle and gives no result; slots at or above MAX_VERTICES are ignored.
//   command = query tests point (coord_x, coord_y) against the first n
//   vertices, n = vertex_count clamped to 3 .. MAX_VERTICES.
//   A query rotates the first n ring slots one slot per cycle; the edge
//   unit behind it adds three pipeline stages, then done pulses with
//   inside_res, winding_number, is_convex. busy is high from a query
//   request through the done cycle; one load per cycle while busy is low.
//   done is a single-cycle strobe; the receiver cannot stall it.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr
//   (0 vertex_count, 1 test_mode); the user writes only while busy is low,
//   and the block itself does not enforce it.
//   Reset: vertex_count 3, test_mode crossing parity, engine idle; vertex
//   contents are undefined until loaded.
// ---------------------------------------------------------------------------
module point_in_polygon_tester #(
	parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [pip_pkg::INDEX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::IN_COORD_W-1:0] coord_x,
	input  logic signed [pip_pkg::IN_COORD_W-1:0] coord_y,
	output logic                                 done,
	output logic                                 inside_res,
	output logic signed [pip_pkg::WN_W-1:0]      winding_number,
	output logic                                 is_convex,
	input  logic                                 cfg_we,
	input  logic [pip_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [pip_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	localparam int CW = COORD_BITS;
	localparam int NW = $clog2(MAX_VERTICES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	state_t                           state_q;
	logic [pip_pkg::COUNT_W-1:0]      vcount_q;
	logic [pip_pkg::MODE_W-1:0]       cfg_mode_q;
	logic [pip_pkg::MODE_W-1:0]       mode_q;
	logic [NW-1:0]                    n_q;
	logic [NW-1:0]                    cnt_q;
	logic [2*CW-1:0]                  pt_q;
	logic [2*CW-1:0]                  in_xy;
	logic [2*CW-1:0]                  cell_xy [MAX_VERTICES];
	logic                             accept, q_accept, l_accept, last_step;
	logic [NW-1:0]                    n_sat;
	pip_pkg::step_ctl_t               step;
	logic                             eu_done;

	assign accept    = start && !busy;
	assign q_accept  = accept && (command == pip_pkg::CMD_QUERY);
	assign l_accept  = accept && (command == pip_pkg::CMD_LOAD);
	assign busy      = (state_q != ST_IDLE);
	assign in_xy     = {CW'($unsigned(coord_x)), CW'($unsigned(coord_y))};
	assign last_step = (cnt_q == n_q - NW'(1));

	// clamp the vertex count into 3 .. MAX_VERTICES
	always_comb begin
		if (int'(vcount_q) < 3) begin
			n_sat = NW'(3);
		end else if (int'(vcount_q) > MAX_VERTICES) begin
			n_sat = NW'(MAX_VERTICES);
		end else begin
			n_sat = NW'(vcount_q);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= pip_pkg::RESET_VERTEX_COUNT;
			cfg_mode_q <= pip_pkg::RESET_TEST_MODE;
		end else if (cfg_we) begin
			case (cfg_addr)
				pip_pkg::REG_VERTEX_COUNT: vcount_q   <= cfg_wdata;
				pip_pkg::REG_TEST_MODE:    cfg_mode_q <= pip_pkg::MODE_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// query sequencer: rotate the ring n times, then wait for the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= NW'(3);
			mode_q  <= pip_pkg::RESET_TEST_MODE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_accept) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						n_q     <= n_sat;
						mode_q  <= cfg_mode_q;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + NW'(1);
					if (last_step) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (eu_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the query point
	always_ff @(posedge clk) begin
		if (q_accept) begin
			pt_q <= in_xy;
		end
	end

	// ring of vertex cells; slot n-1 wraps back to slot 0
	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		logic [2*CW-1:0] nxt;
		logic            hit;
		logic            rot;

		assign hit = l_accept && (int'(vertex_index) == i);
		assign rot = (state_q == ST_RUN) && (int'(n_q) > i);
		if (i == MAX_VERTICES - 1) begin : g_end
			assign nxt = cell_xy[0];
		end else begin : g_mid
			assign nxt = (int'(n_q) == i + 1) ? cell_xy[0] : cell_xy[i+1];
		end

		pip_vertex_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk    (clk),
			.load_en(hit),
			.load_xy(in_xy),
			.rot_en (rot),
			.next_xy(nxt),
			.xy     (cell_xy[i])
		);
	end

	assign step.valid = (state_q == ST_RUN);
	assign step.last  = last_step;

	pip_edge_unit #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_edge (
		.clk           (clk),
		.arst_n        (arst_n),
		.clear         (q_accept),
		.mode          (mode_q),
		.step          (step),
		.v0            (cell_xy[0]),
		.v1            (cell_xy[1]),
		.v2            (cell_xy[2]),
		.pt            (pt_q),
		.done          (eu_done),
		.inside_res    (inside_res),
		.winding_number(winding_number),
		.is_convex     (is_convex)
	);

	assign done = eu_done;

	// a result only closes a query in flight
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_DRAIN))
		else $error("result outside drain");

	// the step counter never passes the vertex count
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q < n_q))
		else $error("step counter overrun");

	// the edge walk ends exactly on the last step
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) && last_step) |=> (state_q == ST_DRAIN))
		else $error("walk did not end");

	// result strobe follows the last step through ctl_s1, ctl_s2 and the done register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RUN) && last_step) |=> ##2 done)
		else $error("result latency");

endmodule
